/* rtl/core/chi_square_intersection_kernel_defines.svh */
// Assertion macros shared by the kernel accumulator RTL.
// Checks are compiled in unless SYNTHESIS is defined; no other dependencies.
`ifndef CHI_SQUARE_INTERSECTION_KERNEL_DEFINES_SVH
`define CHI_SQUARE_INTERSECTION_KERNEL_DEFINES_SVH

`ifndef SYNTHESIS
`define CSIK_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define CSIK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define CSIK_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define CSIK_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/core/csik_pkg.sv */
// Shared types and constants of the kernel accumulator.
// Used by csik_front, csik_queue, csik_back and the top level; no dependencies.
`timescale 1ns / 1ps

package csik_pkg;

   localparam int FEAT_W     = 16;
   localparam int SUM_W      = FEAT_W + 1;
   localparam int SQ_W       = 2 * FEAT_W;
   localparam int ACC_W      = 30;
   localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;

   localparam logic MODE_CHI_SQUARE = 1'b0;
   localparam logic MODE_INTERSECT  = 1'b1;

   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

   // Quotient never exceeds 16 bits, so only the low numerator half needs steps.
   localparam int DIV_STEPS = FEAT_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   typedef enum logic {
      TERM_DIRECT,
      TERM_DIVIDE
   } term_kind_type;

   typedef struct packed {
      term_kind_type    kind;
      logic             last;
      logic [SQ_W-1:0]  num;
      logic [SUM_W-1:0] den;
   } entry_type;

endpackage

/* rtl/core/csik_front.sv */
// Front end: holds the mode register, classifies each request and forms its operands.
// Depends on csik_pkg.
`timescale 1ns / 1ps

module csik_front
   import csik_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data,
   input  logic [FEAT_W-1:0]     feature_a,
   input  logic [FEAT_W-1:0]     feature_b,
   input  logic                  last_element,
   output entry_type             entry
);

   logic              mode_ff;
   logic              mode_in;
   logic [FEAT_W-1:0] diff;
   logic [FEAT_W-1:0] least;
   logic [SUM_W-1:0]  pair_sum;

   assign mode_in = csr_wr_en ? csr_wr_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_CHI_SQUARE;
      end else begin
         mode_ff <= mode_in;
      end
   end

   always_comb begin
      diff     = (feature_a > feature_b) ? (feature_a - feature_b) : (feature_b - feature_a);
      least    = (feature_a < feature_b) ? feature_a : feature_b;
      pair_sum = {1'b0, feature_a} + {1'b0, feature_b};

      entry.last = last_element;
      entry.den  = pair_sum;
      if (mode_ff == MODE_INTERSECT) begin
         entry.kind = TERM_DIRECT;
         entry.num  = {{(SQ_W-FEAT_W){1'b0}}, least};
      end else if (pair_sum == '0) begin
         // zero sum adds nothing: skip the divider
         entry.kind = TERM_DIRECT;
         entry.num  = '0;
      end else begin
         entry.kind = TERM_DIVIDE;
         entry.num  = diff * diff;
      end
   end

endmodule

/* rtl/core/csik_queue.sv */
// Short queue between front and back end, held in flip-flops.
// Depends on csik_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "chi_square_intersection_kernel_defines.svh"

module csik_queue
   import csik_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head_entry
);

   entry_type          slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] result;
      if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
         result = '0;
      end else begin
         result = ptr + 1'b1;
      end
      return result;
   endfunction

   assign full       = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `CSIK_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= COUNT_W'(QUEUE_DEPTH))
   `CSIK_ASSERT_IMPLIES(a_no_pop_empty, clock, reset, pop, count_ff != '0)
   `CSIK_ASSERT_IMPLIES(a_no_push_full, clock, reset, push, !full)
   `CSIK_ASSERT_NEXT(a_push_fills, clock, reset, push && !pop, count_ff != '0)

endmodule

/* rtl/core/csik_back.sv */
// Back end: restoring divider, saturating accumulator and result register.
// Depends on csik_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "chi_square_intersection_kernel_defines.svh"

module csik_back
   import csik_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  entry_type        head_entry,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [ACC_W-1:0] rsp_value,
   output logic             rsp_saturated
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_ACC
   } state_type;

   state_type         state_ff, state_in;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [FEAT_W-1:0] quo_ff, quo_in;
   logic [SUM_W-1:0]  den_ff, den_in;
   logic              last_ff, last_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [ACC_W-1:0]  run_ff, run_in;
   logic              clip_ff, clip_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ACC_W-1:0]  rsp_value_ff, rsp_value_in;
   logic              rsp_sat_ff, rsp_sat_in;

   logic              rsp_free;
   logic              acc_fire;
   logic              acc_last;
   logic [FEAT_W-1:0] term;
   logic [SUM_W:0]    partial;
   logic [SUM_W+1:0]  trial;
   logic              fits;
   logic [ACC_W:0]    wide_sum;
   logic              over;
   logic [ACC_W-1:0]  new_run;
   logic              new_clip;

   assign rsp_free      = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_saturated = rsp_sat_ff;

   // one quotient bit per step
   always_comb begin
      partial = {rem_ff, quo_ff[FEAT_W-1]};
      trial   = {1'b0, partial} - {2'b00, den_ff};
      fits    = !trial[SUM_W+1];
   end

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      den_in       = den_ff;
      last_in      = last_ff;
      step_in      = step_ff;
      pop          = 1'b0;
      acc_fire     = 1'b0;
      acc_last     = 1'b0;
      term         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               if (head_entry.kind == TERM_DIVIDE) begin
                  pop      = 1'b1;
                  rem_in   = {1'b0, head_entry.num[SQ_W-1:FEAT_W]};
                  quo_in   = head_entry.num[FEAT_W-1:0];
                  den_in   = head_entry.den;
                  last_in  = head_entry.last;
                  step_in  = '0;
                  state_in = ST_DIV;
               end else if (!head_entry.last || rsp_free) begin
                  pop      = 1'b1;
                  acc_fire = 1'b1;
                  acc_last = head_entry.last;
                  term     = head_entry.num[FEAT_W-1:0];
               end
            end
         end
         ST_DIV: begin
            rem_in  = fits ? trial[SUM_W-1:0] : partial[SUM_W-1:0];
            quo_in  = {quo_ff[FEAT_W-2:0], fits};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (!last_ff || rsp_free) begin
               acc_fire = 1'b1;
               acc_last = last_ff;
               term     = quo_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // saturating accumulate and result hand-off
   always_comb begin
      wide_sum     = {1'b0, run_ff} + {{(ACC_W+1-FEAT_W){1'b0}}, term};
      over         = wide_sum[ACC_W];
      new_run      = over ? ACC_MAX : wide_sum[ACC_W-1:0];
      new_clip     = clip_ff || over;

      run_in       = run_ff;
      clip_in      = clip_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_sat_in   = rsp_sat_ff;
      if (acc_fire) begin
         if (acc_last) begin
            rsp_valid_in = 1'b1;
            rsp_value_in = new_run;
            rsp_sat_in   = new_clip;
            run_in       = '0;
            clip_in      = 1'b0;
         end else begin
            run_in  = new_run;
            clip_in = new_clip;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         run_ff       <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         run_ff       <= run_in;
         clip_ff      <= clip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      den_ff       <= den_in;
      last_ff      <= last_in;
      step_ff      <= step_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   `CSIK_ASSERT_IMPLIES(a_div_den_nonzero, clock, reset, state_ff == ST_DIV, den_ff != '0)
   `CSIK_ASSERT_IMPLIES(a_div_rem_below, clock, reset, state_ff == ST_DIV, rem_ff < den_ff)
   `CSIK_ASSERT_IMPLIES(a_clip_pins_sum, clock, reset, clip_ff, run_ff == ACC_MAX)
   `CSIK_ASSERT_IMPLIES(a_emit_has_room, clock, reset, acc_fire && acc_last, rsp_free)

endmodule

/* rtl/core/chi_square_intersection_kernel.sv */
// Chi-square / histogram-intersection kernel accumulator, top level.
// Instantiates csik_front, csik_queue and csik_back; depends on csik_pkg.
//
// Each request carries one pair of unsigned Q0.16 feature elements. In chi-square mode
// (kernel_mode 0) the pair adds (a-b)^2/(a+b), quotient truncated, nothing for a zero sum;
// in intersection mode (kernel_mode 1) it adds min(a,b). The Q14.16 sum saturates at
// 2^30-1 and is emitted with a sticky clip flag on the request marked tlast, then cleared.
// Throughput: an intersection pair, or a chi-square pair with a zero sum, is added directly;
// any other chi-square pair passes the back end as a load, 16 steps of the restoring divider
// retiring one quotient bit a cycle, and an accumulate, so the divider sets the chi-square
// rate. A two-entry queue lets the front accept requests ahead of the back end, and the
// result register lets work continue while a result waits to be taken.
// Write kernel_mode only while no request is outstanding; each pair uses the mode in force
// when it is accepted. Vector length is unbounded (nominal 4096 elements).
`timescale 1ns / 1ps

module chi_square_intersection_kernel
   import csik_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // configuration: kernel_mode
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data,
   // requests
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [15:0] feature_a, [31:16] feature_b
   input  logic                  req_tlast,  // last_element
   // results
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [29:0] kernel_value, [31:30] zero
   output logic                  rsp_tuser   // saturated
);

   entry_type        front_entry;
   entry_type        head_entry;
   logic             queue_full;
   logic             head_valid;
   logic             pop;
   logic             push;
   logic [ACC_W-1:0] kernel_value;

   // accept whenever the queue has room
   assign req_tready = !queue_full;
   assign push       = req_tvalid && req_tready;

   csik_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .feature_a    (req_tdata[FEAT_W-1:0]),
      .feature_b    (req_tdata[2*FEAT_W-1:FEAT_W]),
      .last_element (req_tlast),
      .entry        (front_entry)
   );

   csik_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   csik_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_entry    (head_entry),
      .pop           (pop),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_value     (kernel_value),
      .rsp_saturated (rsp_tuser)
   );

   // pad the result to whole bytes
   assign rsp_tdata = {{(RSP_DATA_W-ACC_W){1'b0}}, kernel_value};

endmodule
